### hdl/ookpt_pkg.sv
package ookpt_pkg;

    localparam int MAX_BITS_DEF = 32;

    localparam int PULSE_LEN_W = 13;
    localparam int MULT_W      = 8;
    localparam int CODE_W      = 32;
    localparam int BITS_W      = 7;
    localparam int REPS_W      = 16;
    localparam int SENT_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = PULSE_LEN_W;
    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 40;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH_MULT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW_MULT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH_MULT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_MULT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_MULT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW_MULT   = 3'd6;

    localparam logic [PULSE_LEN_W-1:0] PULSE_LEN_RST      = 13'd350;
    localparam logic [MULT_W-1:0]      SYNC_HIGH_MULT_RST = 8'd1;
    localparam logic [MULT_W-1:0]      SYNC_LOW_MULT_RST  = 8'd31;
    localparam logic [MULT_W-1:0]      ZERO_HIGH_MULT_RST = 8'd1;
    localparam logic [MULT_W-1:0]      ZERO_LOW_MULT_RST  = 8'd3;
    localparam logic [MULT_W-1:0]      ONE_HIGH_MULT_RST  = 8'd3;
    localparam logic [MULT_W-1:0]      ONE_LOW_MULT_RST   = 8'd1;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

endpackage

### hdl/ook_pulse_code_transmitter.sv
// On-off-keyed pulse code transmitter. Each input beat is either a one
// microsecond tick (s_tuser low) or a start request (s_tuser high) carrying a
// code word, a bit count of 1 to MAX_BITS and a repeat count. A burst sends
// the low bits of the code most significant first, each bit a high then a low
// segment, and a sync high/low pair after every repeat; segment lengths are
// multiples of pulse_len ticks set through the register port. Every input
// beat gives exactly one output beat with the line level, busy, accepted,
// rejected, done flags and the wrapping count of finished bursts. The block
// takes one beat per clock and each result sits in the output register from
// the cycle after its input beat; s_tready drops only while a result waits
// there and m_tready is low. Register writes take effect at once.
module ook_pulse_code_transmitter
    import ookpt_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // code_value[31:0], bit_count[38:32], repeat_count[54:39], zero fill
    input  logic [S_DATA_W-1:0]   s_tdata,
    // kind[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // line_level[0], busy_res[1], accepted[2], rejected[3], done_res[4],
    // sent_count[36:5], zero fill
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int BIT_W = $clog2(MAX_BITS);
    localparam int FB_W  = $clog2(MAX_BITS + 1);

    typedef enum logic [1:0] {
        PH_DATA_HIGH,
        PH_DATA_LOW,
        PH_SYNC_HIGH,
        PH_SYNC_LOW
    } phase_t;

    logic [PULSE_LEN_W-1:0] pulse_len_reg;
    logic [MULT_W-1:0]      sync_hi_reg, sync_lo_reg;
    logic [MULT_W-1:0]      zero_hi_reg, zero_lo_reg;
    logic [MULT_W-1:0]      one_hi_reg, one_lo_reg;

    logic                   active_reg, active_next;
    logic [CODE_W-1:0]      code_reg, code_next;
    logic [BIT_W-1:0]       bit_index_reg, bit_index_next;
    logic [FB_W-1:0]        frame_bits_reg, frame_bits_next;
    logic [REPS_W-1:0]      reps_reg, reps_next;
    phase_t                 phase_reg, phase_next;
    logic [PULSE_LEN_W-1:0] tick_reg, tick_next;
    logic [MULT_W-1:0]      pulse_reg, pulse_next;
    logic                   line_reg, line_next;
    logic [SENT_W-1:0]      sent_reg, sent_next;

    logic                   m_valid_reg;
    logic [M_DATA_W-1:0]    m_data_reg;

    logic                   s_beat;
    logic                   in_kind;
    logic [CODE_W-1:0]      in_code;
    logic [BITS_W-1:0]      in_bits;
    logic [REPS_W-1:0]      in_reps;

    logic [PULSE_LEN_W-1:0] plen;
    logic [5:0]             bit_idx6;
    logic                   bit_is_one;
    logic [MULT_W-1:0]      mult_raw, mult_eff;
    logic [PULSE_LEN_W-1:0] tick_inc;
    logic [MULT_W-1:0]      pulse_inc;
    logic [REPS_W-1:0]      reps_dec;
    logic                   pulse_end, seg_end;
    logic                   acc, rej, done;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign in_kind = s_tuser;
    assign in_code = s_tdata[31:0];
    assign in_bits = s_tdata[38:32];
    assign in_reps = s_tdata[54:39];

    // current bit and segment length
    always_comb begin
        plen       = (pulse_len_reg == '0) ? PULSE_LEN_W'(1) : pulse_len_reg;
        bit_idx6   = 6'(bit_index_reg);
        bit_is_one = !bit_idx6[5] && code_reg[bit_idx6[4:0]];
        case (phase_reg)
            PH_DATA_HIGH: mult_raw = bit_is_one ? one_hi_reg : zero_hi_reg;
            PH_DATA_LOW:  mult_raw = bit_is_one ? one_lo_reg : zero_lo_reg;
            PH_SYNC_HIGH: mult_raw = sync_hi_reg;
            PH_SYNC_LOW:  mult_raw = sync_lo_reg;
            default:      mult_raw = sync_lo_reg;
        endcase
        mult_eff  = (mult_raw == '0) ? MULT_W'(1) : mult_raw;
        tick_inc  = tick_reg + PULSE_LEN_W'(1);
        pulse_inc = pulse_reg + MULT_W'(1);
        reps_dec  = reps_reg - REPS_W'(1);
        pulse_end = (tick_inc >= plen);
        seg_end   = pulse_end && (pulse_inc >= mult_eff);
    end

    always_comb begin
        active_next     = active_reg;
        code_next       = code_reg;
        bit_index_next  = bit_index_reg;
        frame_bits_next = frame_bits_reg;
        reps_next       = reps_reg;
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        pulse_next      = pulse_reg;
        line_next       = line_reg;
        sent_next       = sent_reg;
        acc             = 1'b0;
        rej             = 1'b0;
        done            = 1'b0;
        if (s_beat) begin
            if (in_kind == KIND_TICK) begin
                if (active_reg) begin
                    tick_next = pulse_end ? '0 : tick_inc;
                    if (pulse_end) begin
                        pulse_next = seg_end ? '0 : pulse_inc;
                    end
                    if (seg_end) begin
                        case (phase_reg)
                            PH_DATA_HIGH: begin
                                phase_next = PH_DATA_LOW;
                                line_next  = 1'b0;
                            end
                            PH_DATA_LOW: begin
                                if (bit_index_reg == '0) begin
                                    phase_next = PH_SYNC_HIGH;
                                end else begin
                                    bit_index_next = bit_index_reg - BIT_W'(1);
                                    phase_next     = PH_DATA_HIGH;
                                end
                                line_next = 1'b1;
                            end
                            PH_SYNC_HIGH: begin
                                phase_next = PH_SYNC_LOW;
                                line_next  = 1'b0;
                            end
                            default: begin
                                if (reps_dec == '0) begin
                                    done = 1'b1;
                                end else begin
                                    reps_next      = reps_dec;
                                    bit_index_next = BIT_W'(frame_bits_reg - FB_W'(1));
                                    phase_next     = PH_DATA_HIGH;
                                    line_next      = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end else if (active_reg || in_bits == '0 || in_bits > BITS_W'(MAX_BITS)) begin
                rej = 1'b1;
            end else begin
                acc = 1'b1;
                if (in_reps == '0) begin
                    done = 1'b1;
                end else begin
                    active_next     = 1'b1;
                    code_next       = in_code;
                    frame_bits_next = FB_W'(in_bits);
                    bit_index_next  = BIT_W'(in_bits - BITS_W'(1));
                    reps_next       = in_reps;
                    phase_next      = PH_DATA_HIGH;
                    tick_next       = '0;
                    pulse_next      = '0;
                    line_next       = 1'b1;
                end
            end
            // burst finished
            if (done) begin
                active_next = 1'b0;
                line_next   = 1'b0;
                phase_next  = PH_DATA_HIGH;
                tick_next   = '0;
                pulse_next  = '0;
                reps_next   = '0;
                sent_next   = sent_reg + SENT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_len_reg  <= PULSE_LEN_RST;
            sync_hi_reg    <= SYNC_HIGH_MULT_RST;
            sync_lo_reg    <= SYNC_LOW_MULT_RST;
            zero_hi_reg    <= ZERO_HIGH_MULT_RST;
            zero_lo_reg    <= ZERO_LOW_MULT_RST;
            one_hi_reg     <= ONE_HIGH_MULT_RST;
            one_lo_reg     <= ONE_LOW_MULT_RST;
            active_reg     <= 1'b0;
            code_reg       <= '0;
            bit_index_reg  <= '0;
            frame_bits_reg <= '0;
            reps_reg       <= '0;
            phase_reg      <= PH_DATA_HIGH;
            tick_reg       <= '0;
            pulse_reg      <= '0;
            line_reg       <= 1'b0;
            sent_reg       <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end else begin
            active_reg     <= active_next;
            code_reg       <= code_next;
            bit_index_reg  <= bit_index_next;
            frame_bits_reg <= frame_bits_next;
            reps_reg       <= reps_next;
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            pulse_reg      <= pulse_next;
            line_reg       <= line_next;
            sent_reg       <= sent_next;
            if (s_beat) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {3'b000, sent_next, done, rej, acc, active_next, line_next};
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PULSE_LEN:      pulse_len_reg <= cfg_wdata;
                    REG_SYNC_HIGH_MULT: sync_hi_reg   <= cfg_wdata[MULT_W-1:0];
                    REG_SYNC_LOW_MULT:  sync_lo_reg   <= cfg_wdata[MULT_W-1:0];
                    REG_ZERO_HIGH_MULT: zero_hi_reg   <= cfg_wdata[MULT_W-1:0];
                    REG_ZERO_LOW_MULT:  zero_lo_reg   <= cfg_wdata[MULT_W-1:0];
                    REG_ONE_HIGH_MULT:  one_hi_reg    <= cfg_wdata[MULT_W-1:0];
                    REG_ONE_LOW_MULT:   one_lo_reg    <= cfg_wdata[MULT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    a_idle_line_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (!line_reg && phase_reg == PH_DATA_HIGH && tick_reg == '0))
        else $error("idle transmitter with line or counters not cleared");

    a_acc_rej_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[2] && m_data_reg[3]))
        else $error("beat both accepted and rejected");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[4]) |-> (!m_data_reg[1] && !m_data_reg[0]))
        else $error("done beat with busy or line high");

    a_sent_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> (sent_reg == $past(sent_reg) + SENT_W'($past(done))))
        else $error("sent counter out of step with done");

endmodule
